FILE: sv/lfw_pkg.sv
// ----------------------------------------------------------------------------
// lfw_pkg: shared definitions for the line fold block
// Character codes, register indexes, queue depths and the structs that travel
// between the front end, the back end and the top level.
// ----------------------------------------------------------------------------
package lfw_pkg;

  localparam int BUFFER_COLUMNS_DEF = 64;

  localparam int CHAR_BITS = 8;
  localparam int LW_BITS   = 6;
  localparam int TW_BITS   = 5;
  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;

  localparam logic [LW_BITS-1:0] WIDTH_MIN      = 6'd9;
  localparam logic [LW_BITS-1:0] LINE_WIDTH_RST = 6'd63;
  localparam logic [TW_BITS-1:0] TAB_WIDTH_RST  = 5'd8;

  localparam logic [CHAR_BITS-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_BITS-1:0] FILL_CHAR    = 8'h5F;
  localparam logic [CHAR_BITS-1:0] TAB_CHAR     = 8'h09;
  localparam logic [CHAR_BITS-1:0] NEWLINE_CHAR = 8'h0A;

  // Register indexes, taken from paddr[2].
  localparam logic REG_LINE_WIDTH = 1'b0;
  localparam logic REG_TAB_WIDTH  = 1'b1;

  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_TAB  = 2'd1,
    KIND_NL   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [CHAR_BITS-1:0] ch;
  } cmd_t;

  // Effective (already clamped) settings.
  typedef struct packed {
    logic [LW_BITS-1:0] width;
    logic [TW_BITS-1:0] tab;
  } cfg_t;

  typedef struct packed {
    logic idle;
    logic out_push;
    logic out_full;
  } sts_t;

endpackage

FILE: sv/lfw_queue.sv
// ----------------------------------------------------------------------------
// lfw_queue: small synchronous FIFO
// Register based first-in first-out queue with a fill count.
// ----------------------------------------------------------------------------
module lfw_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [WIDTH-1:0]             push_data,
  output logic                         full,
  input  logic                         pop,
  output logic [WIDTH-1:0]             pop_data,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CNW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNW'(1);
      end
    end
  end

endmodule

FILE: sv/lfw_front.sv
// ----------------------------------------------------------------------------
// lfw_front: input side of the line fold block
// Accepts characters, sorts them into tab, newline and ordinary words, and
// queues the classified commands for the back end.
// ----------------------------------------------------------------------------
module lfw_front
  import lfw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [CHAR_BITS-1:0] in_char,
  input  logic                 cmd_pop,
  output logic                 cmd_empty,
  output cmd_t                 cmd_data
);

  cmd_t                  cmd_in;
  logic [$bits(cmd_t)-1:0] cmd_raw;

  always_comb begin
    cmd_in.ch = in_char;
    priority if (in_char == TAB_CHAR) begin
      cmd_in.kind = KIND_TAB;
    end else if (in_char == NEWLINE_CHAR) begin
      cmd_in.kind = KIND_NL;
    end else begin
      cmd_in.kind = KIND_CHAR;
    end
  end

  lfw_queue #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (cmd_in),
    .full      (full),
    .pop       (cmd_pop),
    .pop_data  (cmd_raw),
    .empty     (cmd_empty),
    .count     ()
  );

  assign cmd_data = cmd_t'(cmd_raw);

endmodule

FILE: sv/lfw_back.sv
// ----------------------------------------------------------------------------
// lfw_back: line buffer and sequencer of the line fold block
// Holds the current line in a memory, expands tabs, searches for the break,
// emits lines into the result queue and moves the leftover to the front.
// ----------------------------------------------------------------------------
module lfw_back
  import lfw_pkg::*;
#(
  parameter int BUFFER_COLUMNS = BUFFER_COLUMNS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic                 cmd_empty,
  input  cmd_t                 cmd_data,
  output logic                 cmd_pop,
  input  logic                 pop,
  output logic                 empty,
  output logic [CHAR_BITS-1:0] out_char,
  output logic                 end_of_run,
  output sts_t                 sts
);

  localparam int CW  = $clog2(BUFFER_COLUMNS);
  localparam int MSW = $clog2(CW);
  localparam int OCW = $clog2(OUT_DEPTH + 1);
  localparam int ODW = CHAR_BITS + 1;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MOD    = 7'b0000010,
    S_FILL   = 7'b0000100,
    S_SEARCH = 7'b0001000,
    S_EMIT   = 7'b0010000,
    S_NL     = 7'b0100000,
    S_MOVE   = 7'b1000000
  } state_t;

  typedef enum logic [2:0] {
    TAIL_NONE = 3'b001,
    TAIL_PUT  = 3'b010,
    TAIL_MOVE = 3'b100
  } tail_t;

  state_t               state;
  tail_t                tail_op;
  logic [CW-1:0]        col;
  logic [CHAR_BITS-1:0] ch;
  logic [CW-1:0]        phase;
  logic [MSW-1:0]       mshift;
  logic [CW-1:0]        scan;
  logic [CW-1:0]        chk_pos;
  logic                 chk_vld;
  logic [CW-1:0]        idx;
  logic [CW-1:0]        cnt;
  logic                 pend;
  logic [CW-1:0]        src;
  logic [CW-1:0]        dst;
  logic                 mv_vld;

  logic [CHAR_BITS-1:0] line_store [BUFFER_COLUMNS];
  logic [CHAR_BITS-1:0] rd_data;
  logic                 we;
  logic [CW-1:0]        wa;
  logic [CHAR_BITS-1:0] wd;
  logic [CW-1:0]        ra;

  logic [CW-1:0]         w;
  logic [CW-1:0]         wm1;
  logic [CW-1:0]         col_eff;
  logic [CW+TW_BITS-1:0] tsh;
  logic [CW+TW_BITS-1:0] phase_ext;
  logic [CW+TW_BITS-1:0] phase_inc;
  logic [CW+TW_BITS-1:0] tab_ext;
  logic                  mod_ge;
  logic                  found;
  logic                  issue;
  logic                  space;
  logic [OCW:0]          used;

  logic                 push;
  logic [ODW-1:0]       push_word;
  logic [ODW-1:0]       out_word;
  logic                 out_full;
  logic [OCW-1:0]       out_count;

  assign w       = cfg.width[CW-1:0];
  assign wm1     = w - CW'(1);
  assign col_eff = (col > wm1) ? wm1 : col;

  assign tsh       = {{CW{1'b0}}, cfg.tab} << mshift;
  assign phase_ext = {{TW_BITS{1'b0}}, phase};
  assign phase_inc = phase_ext + (CW + TW_BITS)'(1);
  assign tab_ext   = {{CW{1'b0}}, cfg.tab};
  assign mod_ge    = (phase_ext >= tsh);

  assign found = chk_vld && ((rd_data == BLANK_CHAR) || (chk_pos == '0));
  assign used  = {1'b0, out_count} + {{OCW{1'b0}}, pend};
  assign space = (used < (OCW + 1)'(OUT_DEPTH));
  assign issue = (state == S_EMIT) && (idx != cnt) && space;

  // Line memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      line_store[wa] <= wd;
    end
    rd_data <= line_store[ra];
  end

  always_comb begin
    cmd_pop   = 1'b0;
    we        = 1'b0;
    wa        = col;
    wd        = ch;
    ra        = idx;
    push      = pend;
    push_word = {rd_data, 1'b0};
    unique case (state)
      S_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          if ((cmd_data.kind != KIND_TAB) && (cmd_data.kind != KIND_NL) &&
              (col_eff != wm1)) begin
            we = 1'b1;
            wa = col_eff;
            wd = cmd_data.ch;
          end
        end
      end
      S_FILL: begin
        we = 1'b1;
        wa = col;
        wd = FILL_CHAR;
      end
      S_SEARCH: begin
        ra = scan;
      end
      S_NL: begin
        if (!pend && space) begin
          push      = 1'b1;
          push_word = {NEWLINE_CHAR, 1'b1};
          if (tail_op == TAIL_PUT) begin
            we = 1'b1;
            wa = '0;
            wd = ch;
          end
        end
      end
      S_MOVE: begin
        ra = src;
        if (mv_vld) begin
          we = 1'b1;
          wa = dst;
          wd = rd_data;
        end else if (src == col) begin
          we = 1'b1;
          wa = dst;
          wd = ch;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      tail_op <= TAIL_NONE;
      col     <= '0;
      pend    <= 1'b0;
      chk_vld <= 1'b0;
      mv_vld  <= 1'b0;
    end else begin
      pend <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!cmd_empty) begin
            ch  <= cmd_data.ch;
            col <= col_eff;
            unique case (cmd_data.kind)
              KIND_TAB: begin
                phase  <= col_eff;
                mshift <= MSW'(CW - 1);
                state  <= S_MOD;
              end
              KIND_NL: begin
                cnt     <= col_eff;
                idx     <= '0;
                tail_op <= TAIL_NONE;
                state   <= S_EMIT;
              end
              default: begin
                if (col_eff == wm1) begin
                  scan    <= col_eff - CW'(1);
                  chk_vld <= 1'b0;
                  state   <= S_SEARCH;
                end else begin
                  col <= col_eff + CW'(1);
                end
              end
            endcase
          end
        end
        S_MOD: begin
          if (mod_ge) begin
            phase <= phase - tsh[CW-1:0];
          end
          if (mshift == '0) begin
            state <= S_FILL;
          end else begin
            mshift <= mshift - MSW'(1);
          end
        end
        S_FILL: begin
          col   <= col + CW'(1);
          phase <= phase + CW'(1);
          priority if (col == wm1) begin
            cnt     <= wm1;
            idx     <= '0;
            tail_op <= TAIL_NONE;
            state   <= S_EMIT;
          end else if (phase_inc == tab_ext) begin
            state <= S_IDLE;
          end
        end
        S_SEARCH: begin
          if (found) begin
            chk_vld <= 1'b0;
            idx     <= '0;
            state   <= S_EMIT;
            if (chk_pos == '0) begin
              cnt     <= col;
              tail_op <= TAIL_PUT;
            end else begin
              cnt     <= chk_pos + CW'(1);
              src     <= chk_pos + CW'(1);
              tail_op <= TAIL_MOVE;
            end
          end else begin
            chk_vld <= 1'b1;
            chk_pos <= scan;
            if (scan != '0) begin
              scan <= scan - CW'(1);
            end
          end
        end
        S_EMIT: begin
          pend <= issue;
          if (issue) begin
            idx <= idx + CW'(1);
          end else if (idx == cnt) begin
            state <= S_NL;
          end
        end
        S_NL: begin
          if (!pend && space) begin
            unique case (tail_op)
              TAIL_PUT: begin
                col   <= CW'(1);
                state <= S_IDLE;
              end
              TAIL_MOVE: begin
                mv_vld <= 1'b0;
                dst    <= '0;
                state  <= S_MOVE;
              end
              default: begin
                col   <= '0;
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_MOVE: begin
          mv_vld <= 1'b0;
          if (src != col) begin
            mv_vld <= 1'b1;
            src    <= src + CW'(1);
          end
          if (mv_vld) begin
            dst <= dst + CW'(1);
          end else if (src == col) begin
            col   <= dst + CW'(1);
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  lfw_queue #(
    .WIDTH (ODW),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_word),
    .full      (out_full),
    .pop       (pop),
    .pop_data  (out_word),
    .empty     (empty),
    .count     (out_count)
  );

  assign out_char   = out_word[ODW-1:1];
  assign end_of_run = out_word[0];

  assign sts.idle     = (state == S_IDLE);
  assign sts.out_push = push;
  assign sts.out_full = out_full;

endmodule

FILE: sv/line_fold_word_wrap.sv
// ----------------------------------------------------------------------------
// line_fold_word_wrap: word wrap for a character stream
// Folds a stream of characters into lines no longer than a set width,
// breaking at blanks and expanding tabs into fill characters.
// ----------------------------------------------------------------------------
// Characters are pushed one word at a time and the folded text is popped one
// word at a time; each popped word carries end_of_run on the newline that
// closes an emitted line, which is always the last word caused by an input
// character. A front end classifies characters into a two-entry command queue
// and a back end works through them against a line memory of BUFFER_COLUMNS
// bytes, so input can go on into the command queue while the back end is busy
// or the result side is stalled. Timing is set by the back end, which handles
// one character at a time through the line memory with its one write port and
// one read port. An ordinary character that does not fold is written to the
// line memory as it is taken. A newline emits the words of its line, one per
// cycle while the four-entry result queue has space, and then the newline word.
// A tab finds its column within the tab stop by shift and subtract and then
// writes fill characters up to the next stop, emitting the line when it fills
// it. A fold scans backward one column per cycle for the blank, emits the line
// head at one word per cycle while the result queue has space and then moves
// the leftover one character per cycle to the front of the line. The
// configuration registers (line_width at address 0, tab_width at address 4)
// may only be written while the block is idle; line_width is clamped to the
// range 9 to BUFFER_COLUMNS-1 and a tab_width of zero acts as one. Nothing is
// flushed at the end of input, and no memory clearing is needed after reset.
// ----------------------------------------------------------------------------
module line_fold_word_wrap
  import lfw_pkg::*;
#(
  parameter int BUFFER_COLUMNS = BUFFER_COLUMNS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // Character input
  input  logic                 push,
  output logic                 full,
  input  logic [CHAR_BITS-1:0] in_char,
  // Folded output
  input  logic                 pop,
  output logic                 empty,
  output logic [CHAR_BITS-1:0] out_char,
  output logic                 end_of_run,
  // Register port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  logic [LW_BITS-1:0] line_width;
  logic [TW_BITS-1:0] tab_width;
  logic               reg_write;
  cfg_t               cfg;
  cmd_t               cmd_data;
  logic               cmd_empty;
  logic               cmd_pop;
  sts_t               sts;

  // The widest usable line leaves one column of the buffer free.
  localparam logic [LW_BITS:0] WIDTH_MAX = (LW_BITS + 1)'(BUFFER_COLUMNS - 1);

  // Register port: always ready, writes land on the access cycle.
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RST;
      tab_width  <= TAB_WIDTH_RST;
    end else if (reg_write) begin
      unique case (paddr[2])
        REG_LINE_WIDTH: line_width <= pwdata[LW_BITS-1:0];
        REG_TAB_WIDTH:  tab_width  <= pwdata[TW_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_LINE_WIDTH: prdata = {{(DATA_BITS - LW_BITS){1'b0}}, line_width};
      REG_TAB_WIDTH:  prdata = {{(DATA_BITS - TW_BITS){1'b0}}, tab_width};
    endcase
  end

  // Effective settings: the width is held between the minimum and one less
  // than the buffer size, and a zero tab stop distance behaves as one column.
  always_comb begin
    priority if (line_width < WIDTH_MIN) begin
      cfg.width = WIDTH_MIN;
    end else if ({1'b0, line_width} > WIDTH_MAX) begin
      cfg.width = WIDTH_MAX[LW_BITS-1:0];
    end else begin
      cfg.width = line_width;
    end
    cfg.tab = (tab_width == '0) ? TW_BITS'(1) : tab_width;
  end

  lfw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_char   (in_char),
    .cmd_pop   (cmd_pop),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_data)
  );

  lfw_back #(
    .BUFFER_COLUMNS (BUFFER_COLUMNS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd_empty  (cmd_empty),
    .cmd_data   (cmd_data),
    .cmd_pop    (cmd_pop),
    .pop        (pop),
    .empty      (empty),
    .out_char   (out_char),
    .end_of_run (end_of_run),
    .sts        (sts)
  );

  // Newlines are never stored, so a newline word is exactly the closing
  // word of a run and every other word comes from the line memory.
  a_newline_closes_run: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (end_of_run == (out_char == NEWLINE_CHAR)))
    else $error("end_of_run does not match the newline word");

  // The back end reserves result queue space before it reads the memory,
  // so a word is never pushed into a full result queue.
  a_no_result_overflow: assert property (@(posedge clk) disable iff (rst)
    sts.out_push |-> !sts.out_full)
    else $error("word pushed into a full result queue");

  // After reset both queues are empty and the sequencer waits for work.
  a_reset_clean: assert property (@(posedge clk)
    rst |=> (empty && !full && sts.idle))
    else $error("block not clean after reset");

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the line fold block
// Streams character words into the block, predicts the folded text from a
// behavioral line model, and compares every popped word against it while
// both sides of the block stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import lfw_pkg::*;

  // The longest stretch the receiver holds off on purpose, in cycles.
  localparam int LONG_HOLD      = 400;
  // A fold moves the leftover one column per cycle after its last word is out,
  // so this many cycles pass before the block is treated as idle.
  localparam int SETTLE_CYCLES  = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 40;

  typedef struct packed {
    logic [CHAR_BITS-1:0] ch;
    logic                 last;
  } folded_word_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  logic [CHAR_BITS-1:0] in_char = '0;
  logic                 pop = 1'b0;
  logic                 empty;
  logic [CHAR_BITS-1:0] out_char;
  logic                 end_of_run;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  // Characters waiting to be pushed, and the folded words still owed by the block.
  logic [CHAR_BITS-1:0] char_q[$];
  folded_word_t         folded_q[$];

  // Line model: the text of the current line and how many columns hold text.
  logic [CHAR_BITS-1:0] line_mem[BUFFER_COLUMNS_DEF];
  logic [6:0]           col_cnt;
  logic [LW_BITS-1:0]   lw_cfg;
  logic [TW_BITS-1:0]   tw_cfg;

  int  mismatches = 0;
  int  stuck_cycles = 0;
  int  send_gap = 0;
  int  send_calm = 0;
  int  recv_gap = 0;
  int  recv_calm = 0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  folded_word_t want;

  line_fold_word_wrap dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .in_char    (in_char),
    .pop        (pop),
    .empty      (empty),
    .out_char   (out_char),
    .end_of_run (end_of_run),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // Running text: words of lower case letters between blanks, with the odd
  // newline, tab, capital or arbitrary byte thrown in.
  function automatic logic [CHAR_BITS-1:0] text_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 8'h61 + 8'($urandom_range(0, 25));
    else if (r < 76) return BLANK_CHAR;
    else if (r < 80) return NEWLINE_CHAR;
    else if (r < 85) return TAB_CHAR;
    else if (r < 90) return 8'h41 + 8'($urandom_range(0, 25));
    else return 8'($urandom_range(0, 255));
  endfunction

  // Emits the first count columns of the line followed by a newline.
  task automatic emit_head(input int count);
    folded_word_t wd;
    wd.last = 1'b0;
    for (int i = 0; i < count && i < BUFFER_COLUMNS_DEF; i++) begin
      wd.ch = line_mem[i];
      folded_q.push_back(wd);
    end
    wd.ch = NEWLINE_CHAR;
    folded_q.push_back(wd);
  endtask

  // Works out the words one accepted character causes and updates the line.
  task automatic fold_predict(input logic [CHAR_BITS-1:0] ch);
    int width;
    int stop;
    int c;
    int p;
    int dst;
    int first;
    folded_word_t tail;
    width = int'(lw_cfg);
    if (width < int'(WIDTH_MIN)) width = int'(WIDTH_MIN);
    if (width > BUFFER_COLUMNS_DEF - 1) width = BUFFER_COLUMNS_DEF - 1;
    stop = (tw_cfg == 0) ? 1 : int'(tw_cfg);
    c = int'(col_cnt);
    first = folded_q.size();
    // A line left longer than a newly narrowed width loses its excess.
    if (c > width - 1) c = width - 1;
    if (ch == TAB_CHAR) begin
      line_mem[c] = FILL_CHAR;
      c++;
      while (c < width && (c % stop) != 0) begin
        line_mem[c] = FILL_CHAR;
        c++;
      end
      // A tab that reaches the width flushes the whole line.
      if (c >= width) begin
        emit_head(width - 1);
        c = 0;
      end
    end else if (ch == NEWLINE_CHAR) begin
      emit_head(c);
      c = 0;
    end else begin
      if (c + 1 >= width) begin
        // Look back for a blank, never as far as column zero.
        p = (c != 0) ? c - 1 : 0;
        while (p > 0 && line_mem[p] != BLANK_CHAR) p--;
        if (p == 0) begin
          emit_head(c);
          c = 0;
        end else begin
          emit_head(p + 1);
          dst = 0;
          for (int s = p + 1; s < c; s++) begin
            line_mem[dst] = line_mem[s];
            dst++;
          end
          c = dst;
        end
      end
      line_mem[c] = ch;
      c++;
    end
    col_cnt = 7'(c);
    if (folded_q.size() > first) begin
      tail = folded_q.pop_back();
      tail.last = 1'b1;
      folded_q.push_back(tail);
    end
  endtask

  // Sender: offers the pending characters with random gaps and feeds every
  // accepted one to the line model.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) fold_predict(in_char);
      if (!push || !full) begin
        if (send_gap != 0) begin
          send_gap = send_gap - 1;
          push <= 1'b0;
        end else if (char_q.size() != 0) begin
          push <= 1'b1;
          in_char <= char_q.pop_front();
          if (send_calm != 0) begin
            send_calm = send_calm - 1;
            send_gap = 0;
          end else begin
            send_gap = idle_len();
            if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(20, 80);
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver: pops folded words with random stalls and checks each one
  // against the oldest word the line model owes.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (folded_q.size() == 0) begin
          $display("%0t: word with none expected, out_char %h end_of_run %b",
                   $time, out_char, end_of_run);
          mismatches++;
        end else begin
          want = folded_q.pop_front();
          if (out_char !== want.ch) begin
            $display("%0t: out_char expected %h, got %h", $time, want.ch, out_char);
            mismatches++;
          end
          if (end_of_run !== want.last) begin
            $display("%0t: end_of_run expected %b, got %b", $time, want.last, end_of_run);
            mismatches++;
          end
        end
        if (recv_calm != 0) begin
          recv_calm = recv_calm - 1;
          recv_gap = 0;
        end else begin
          recv_gap = idle_len();
          if ($urandom_range(0, 39) == 0) recv_calm = $urandom_range(20, 80);
        end
      end
      // One long hold-off, so the block backs up and stalls its input.
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        recv_gap = LONG_HOLD;
      end
      if (recv_gap != 0) begin
        recv_gap = recv_gap - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Ends a run in which no word moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == WATCHDOG_LIMIT) begin
      $display("line_fold_word_wrap: mismatch");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic reg_write(input logic idx, input int unsigned value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_LINE_WIDTH) lw_cfg = value[LW_BITS-1:0];
    else tw_cfg = value[TW_BITS-1:0];
  endtask

  // Holds the sender back until every owed word has been popped and the
  // block has had time to finish any leftover move.
  task automatic wait_drained();
    do @(negedge clk); while (char_q.size() != 0 || push || folded_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_widths(input int unsigned lw, input int unsigned tw);
    wait_drained();
    reg_write(REG_LINE_WIDTH, lw);
    reg_write(REG_TAB_WIDTH, tw);
    @(negedge clk);
  endtask

  task automatic add_text(input int count);
    int made;
    made = 0;
    @(negedge clk);
    while (made < count) begin
      // Now and then a long word with no blank, to force a hard fold.
      if ($urandom_range(0, 14) == 0) begin
        repeat ($urandom_range(10, 30)) begin
          char_q.push_back(8'h41 + 8'($urandom_range(0, 25)));
          made++;
        end
      end else begin
        char_q.push_back(text_char());
        made++;
      end
    end
  endtask

  initial begin
    foreach (line_mem[i]) line_mem[i] = BLANK_CHAR;
    col_cnt = '0;
    lw_cfg = LINE_WIDTH_RST;
    tw_cfg = TAB_WIDTH_RST;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // A width of zero acts as the narrowest line and a zero tab width as one.
    // Starts with a newline on an empty line, then a fold at a blank that
    // moves the leftover, then a newline on a part line.
    set_widths(0, 0);
    char_q.push_back(NEWLINE_CHAR);
    char_q.push_back(8'h61);
    char_q.push_back(TAB_CHAR);
    char_q.push_back(BLANK_CHAR);
    char_q.push_back(8'h00);
    char_q.push_back(8'hFF);
    char_q.push_back(8'h78);
    char_q.push_back(8'h79);
    char_q.push_back(8'h7A);
    char_q.push_back(8'h71);
    char_q.push_back(NEWLINE_CHAR);

    // Widest line and a tab stop of 16: tabs run the line out to the width and
    // flush it, then two more tabs leave a half line of fill characters.
    set_widths(63, 16);
    char_q.push_back(8'h6B);
    repeat (6) char_q.push_back(TAB_CHAR);

    // Narrowing the width under that half line cuts it back, and the next
    // character folds a line with no blank in it; the last one just stores.
    set_widths(9, 16);
    char_q.push_back(8'h7A);
    char_q.push_back(8'h65);

    set_widths(63, 31);
    hold_req = 1'b1;
    add_text(RANDOM_ITEMS);
    set_widths(9, 1);
    add_text(RANDOM_ITEMS);
    set_widths(12, 3);
    add_text(RANDOM_ITEMS);
    set_widths($urandom_range(0, 63), $urandom_range(0, 31));
    add_text(RANDOM_ITEMS);
    set_widths($urandom_range(0, 63), $urandom_range(0, 31));
    add_text(RANDOM_ITEMS);

    wait_drained();
    if (mismatches == 0 && folded_q.size() == 0) begin
      $display("line_fold_word_wrap: match");
    end else begin
      $display("line_fold_word_wrap: mismatch");
    end
    $finish;
  end

endmodule
